// ===== sv/sgr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sgr_pkg;

  localparam int BYTE_W  = 8;
  localparam int COLOR_W = 3;
  localparam int FLAGS_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int PROD_W  = 12;

  // Parameter text bytes
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_FINAL = 8'h6D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] ACC_MAX  = 8'd255;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FG    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BG    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FLAGS = 2'd2;

  localparam logic [COLOR_W-1:0] RST_FG    = 3'd7;
  localparam logic [COLOR_W-1:0] RST_BG    = 3'd0;
  localparam logic [FLAGS_W-1:0] RST_FLAGS = 5'd0;

  // Flag bit positions
  localparam int FL_BOLD  = 0;
  localparam int FL_DIM   = 1;
  localparam int FL_UNDER = 2;
  localparam int FL_BLINK = 3;
  localparam int FL_REV   = 4;

  // Rendition codes
  localparam logic [BYTE_W-1:0] SGR_RESET      = 8'd0;
  localparam logic [BYTE_W-1:0] SGR_BOLD       = 8'd1;
  localparam logic [BYTE_W-1:0] SGR_DIM        = 8'd2;
  localparam logic [BYTE_W-1:0] SGR_UNDER      = 8'd4;
  localparam logic [BYTE_W-1:0] SGR_BLINK      = 8'd5;
  localparam logic [BYTE_W-1:0] SGR_REV        = 8'd7;
  localparam logic [BYTE_W-1:0] SGR_FONT_PRI   = 8'd10;
  localparam logic [BYTE_W-1:0] SGR_FONT_ALT1  = 8'd11;
  localparam logic [BYTE_W-1:0] SGR_FONT_ALT2  = 8'd12;
  localparam logic [BYTE_W-1:0] SGR_NO_BOLD    = 8'd21;
  localparam logic [BYTE_W-1:0] SGR_NORMAL     = 8'd22;
  localparam logic [BYTE_W-1:0] SGR_NO_UNDER   = 8'd24;
  localparam logic [BYTE_W-1:0] SGR_NO_BLINK   = 8'd25;
  localparam logic [BYTE_W-1:0] SGR_NO_REV     = 8'd27;
  localparam logic [BYTE_W-1:0] SGR_FG_LO      = 8'd30;
  localparam logic [BYTE_W-1:0] SGR_FG_HI      = 8'd37;
  localparam logic [BYTE_W-1:0] SGR_FG_UNDER   = 8'd38;
  localparam logic [BYTE_W-1:0] SGR_FG_DEFAULT = 8'd39;
  localparam logic [BYTE_W-1:0] SGR_BG_LO      = 8'd40;
  localparam logic [BYTE_W-1:0] SGR_BG_HI      = 8'd47;
  localparam logic [BYTE_W-1:0] SGR_BG_DEFAULT = 8'd49;

  typedef struct packed {
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic [FLAGS_W-1:0] flags;
    logic               alt;
  } style_t;

  typedef struct packed {
    logic              apply;
    logic [BYTE_W-1:0] code;
  } token_evt_t;

endpackage

`default_nettype wire

// ===== sv/sgr_token.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sgr_token import sgr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire logic [BYTE_W-1:0] param_byte,
  output token_evt_t             evt
);

  logic [BYTE_W-1:0] accum_r, accum_nxt;
  logic              nonempty_r, nonempty_nxt;
  logic              frozen_r, frozen_nxt;
  logic              is_sep, is_digit;
  logic [PROD_W-1:0] prod;

  assign is_sep   = (param_byte == CH_SEMI) || (param_byte == CH_FINAL);
  assign is_digit = (param_byte >= CH_ZERO) && (param_byte <= CH_NINE);
  // accum * 10 + digit
  assign prod = {1'b0, accum_r, 3'b000} + {3'b000, accum_r, 1'b0}
              + {4'b0000, param_byte - CH_ZERO};

  always_comb begin
    accum_nxt    = accum_r;
    nonempty_nxt = nonempty_r;
    frozen_nxt   = frozen_r;
    evt.apply    = 1'b0;
    evt.code     = accum_r;
    if (is_sep) begin
      evt.apply    = nonempty_r;
      accum_nxt    = '0;
      nonempty_nxt = 1'b0;
      frozen_nxt   = 1'b0;
    end else begin
      nonempty_nxt = 1'b1;
      if (is_digit) begin
        if (!frozen_r) begin
          accum_nxt = (prod > PROD_W'(ACC_MAX)) ? ACC_MAX : prod[BYTE_W-1:0];
        end
      end else begin
        frozen_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r    <= '0;
      nonempty_r <= 1'b0;
      frozen_r   <= 1'b0;
    end else if (advance) begin
      accum_r    <= accum_nxt;
      nonempty_r <= nonempty_nxt;
      frozen_r   <= frozen_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sgr_style.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sgr_style import sgr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  advance,
  input  wire token_evt_t            evt,
  output style_t                     style_next
);

  logic [COLOR_W-1:0] def_fg_r;
  logic [COLOR_W-1:0] def_bg_r;
  logic [FLAGS_W-1:0] def_flags_r;
  style_t             style_r, style_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_fg_r    <= RST_FG;
      def_bg_r    <= RST_BG;
      def_flags_r <= RST_FLAGS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEFAULT_FG:    def_fg_r    <= cfg_data[COLOR_W-1:0];
        CFG_DEFAULT_BG:    def_bg_r    <= cfg_data[COLOR_W-1:0];
        CFG_DEFAULT_FLAGS: def_flags_r <= cfg_data[FLAGS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    style_nxt = style_r;
    if (evt.apply) begin
      unique case (evt.code) inside
        SGR_RESET: begin
          style_nxt.fg    = def_fg_r;
          style_nxt.bg    = def_bg_r;
          style_nxt.flags = def_flags_r;
        end
        SGR_BOLD:  style_nxt.flags[FL_BOLD]  = 1'b1;
        SGR_DIM:   style_nxt.flags[FL_DIM]   = 1'b1;
        SGR_UNDER: style_nxt.flags[FL_UNDER] = 1'b1;
        SGR_BLINK: style_nxt.flags[FL_BLINK] = 1'b1;
        SGR_REV:   style_nxt.flags[FL_REV]   = 1'b1;
        SGR_FONT_PRI: style_nxt.alt = 1'b0;
        SGR_FONT_ALT1, SGR_FONT_ALT2: style_nxt.alt = 1'b1;
        SGR_NO_BOLD, SGR_NORMAL: begin
          style_nxt.flags[FL_BOLD] = 1'b0;
          style_nxt.flags[FL_DIM]  = 1'b0;
        end
        SGR_NO_UNDER: style_nxt.flags[FL_UNDER] = 1'b0;
        SGR_NO_BLINK: style_nxt.flags[FL_BLINK] = 1'b0;
        SGR_NO_REV:   style_nxt.flags[FL_REV]   = 1'b0;
        [SGR_FG_LO:SGR_FG_HI]: begin
          style_nxt.fg = COLOR_W'(evt.code - SGR_FG_LO);
        end
        SGR_FG_UNDER: begin
          style_nxt.fg              = def_fg_r;
          style_nxt.flags[FL_UNDER] = 1'b1;
        end
        SGR_FG_DEFAULT: begin
          style_nxt.fg              = def_fg_r;
          style_nxt.flags[FL_UNDER] = 1'b0;
        end
        [SGR_BG_LO:SGR_BG_HI]: begin
          style_nxt.bg = COLOR_W'(evt.code - SGR_BG_LO);
        end
        SGR_BG_DEFAULT: style_nxt.bg = def_bg_r;
        default: ;
      endcase
    end
  end

  assign style_next = style_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      style_r <= '{fg: RST_FG, bg: RST_BG, flags: RST_FLAGS, alt: 1'b0};
    end else if (advance) begin
      style_r <= style_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sgr_attribute_interpreter.sv =====
// Select-graphic-rendition interpreter.
// Input channel: in_valid / in_stall / in_param_byte carries the bytes that
// follow ESC [ one word at a time. Result channel: out_valid / out_stall
// carries one word per input byte: the style after that byte plus
// out_sequence_done, set when the byte was the final 'm'.
// Configuration: cfg_we with cfg_index / cfg_data writes default_fg (0),
// default_bg (1) or default_flags (2); write only while the block is idle.
// Path: an accepted byte loads the input register, then one pass of token
// and style logic fills the result register, which drives out_valid.
// Throughput: one byte per cycle while no result is stalled; the token
// accumulator and style register update in the same cycle a byte moves
// into the result register.
// Stall: while out_stall holds a waiting result, the input register keeps
// one more byte and then in_stall rises until the result is taken.
// Reset (rst_n low, synchronous): both registers empty, style returns to
// foreground 7, background 0, flags and font clear; defaults to 7 / 0 / 0.
`timescale 1ns / 1ps
`default_nettype none

module sgr_attribute_interpreter import sgr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [BYTE_W-1:0]     in_param_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COLOR_W-1:0]         out_fg_color,
  output logic [COLOR_W-1:0]         out_bg_color,
  output logic                       out_bold,
  output logic                       out_dim,
  output logic                       out_underline,
  output logic                       out_blink,
  output logic                       out_reverse,
  output logic                       out_alternate_font,
  output logic                       out_sequence_done,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic              in_valid_r;
  logic [BYTE_W-1:0] byte_r;
  logic              out_valid_r;
  style_t            out_style_r;
  logic              out_done_r;
  logic              advance;
  logic              in_fire;
  token_evt_t        evt;
  style_t            style_next;

  // advance the input word when the result register is free or being drained
  assign advance  = in_valid_r && !(out_valid_r && out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_r <= in_param_byte;
    end
  end

  sgr_token u_token (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .param_byte (byte_r),
    .evt        (evt)
  );

  sgr_style u_style (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .advance    (advance),
    .evt        (evt),
    .style_next (style_next)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_style_r <= style_next;
      out_done_r  <= (byte_r == CH_FINAL);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_fg_color       = out_style_r.fg;
  assign out_bg_color       = out_style_r.bg;
  assign out_bold           = out_style_r.flags[FL_BOLD];
  assign out_dim            = out_style_r.flags[FL_DIM];
  assign out_underline      = out_style_r.flags[FL_UNDER];
  assign out_blink          = out_style_r.flags[FL_BLINK];
  assign out_reverse        = out_style_r.flags[FL_REV];
  assign out_alternate_font = out_style_r.alt;
  assign out_sequence_done  = out_done_r;

endmodule

`default_nettype wire

// ===== sv/sgr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sgr_checker import sgr_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [COLOR_W-1:0] out_fg_color,
  input wire logic [COLOR_W-1:0] out_bg_color,
  input wire logic               out_sequence_done
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_fg_color)
      && $stable(out_bg_color) && $stable(out_sequence_done))
    else $error("stalled result word changed");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without stalled result");

  // a fresh result must trace back to an accepted input word
  a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result word appeared without input");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sgr_attribute_interpreter sgr_checker u_sgr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_fg_color      (out_fg_color),
  .out_bg_color      (out_bg_color),
  .out_sequence_done (out_sequence_done)
);

`default_nettype wire

// ===== bench/tb_sgr_attribute_interpreter.sv =====
`timescale 1ns / 1ps

module tb_sgr_attribute_interpreter;
  import sgr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int RANDOM_BYTES = 700;
  localparam int HOLD_OFF_CYCLES = 48;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    style_t style;
    logic   done;
  } style_word_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_param_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COLOR_W-1:0]    out_fg_color;
  logic [COLOR_W-1:0]    out_bg_color;
  logic                  out_bold;
  logic                  out_dim;
  logic                  out_underline;
  logic                  out_blink;
  logic                  out_reverse;
  logic                  out_alternate_font;
  logic                  out_sequence_done;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sgr_attribute_interpreter dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_param_byte      (in_param_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_fg_color       (out_fg_color),
    .out_bg_color       (out_bg_color),
    .out_bold           (out_bold),
    .out_dim            (out_dim),
    .out_underline      (out_underline),
    .out_blink          (out_blink),
    .out_reverse        (out_reverse),
    .out_alternate_font (out_alternate_font),
    .out_sequence_done  (out_sequence_done),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Style tracker state, mirrors the block's registers
  style_t             cur_style;
  logic [COLOR_W-1:0] dflt_fg;
  logic [COLOR_W-1:0] dflt_bg;
  logic [FLAGS_W-1:0] dflt_flags;
  logic [BYTE_W-1:0]  tok_value;
  logic               tok_nonempty;
  logic               tok_frozen;

  style_word_t pending_styles[$];

  int errors = 0;
  int bytes_sent = 0;
  int words_checked = 0;
  int cfg_writes = 0;

  // Flow control knobs
  int          burst_left = 0;
  int          gap_max = 4;
  bit          gaps_on = 1'b0;
  logic [15:0] stall_mask = '0;
  int          hold_left = 0;

  logic [BYTE_W-1:0] named_codes [19] = '{
    SGR_RESET, SGR_BOLD, SGR_DIM, SGR_UNDER, SGR_BLINK, SGR_REV,
    SGR_FONT_PRI, SGR_FONT_ALT1, SGR_FONT_ALT2, SGR_NO_BOLD, SGR_NORMAL,
    SGR_NO_UNDER, SGR_NO_BLINK, SGR_NO_REV, SGR_FG_UNDER, SGR_FG_DEFAULT,
    SGR_BG_DEFAULT, SGR_FG_LO, SGR_BG_HI
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic reset_tracker();
    dflt_fg      = RST_FG;
    dflt_bg      = RST_BG;
    dflt_flags   = RST_FLAGS;
    cur_style    = '{fg: RST_FG, bg: RST_BG, flags: RST_FLAGS, alt: 1'b0};
    tok_value    = '0;
    tok_nonempty = 1'b0;
    tok_frozen   = 1'b0;
  endtask

  function automatic void apply_rendition(logic [BYTE_W-1:0] code);
    case (code)
      SGR_RESET: begin
        cur_style.fg    = dflt_fg;
        cur_style.bg    = dflt_bg;
        cur_style.flags = dflt_flags;
      end
      SGR_BOLD:                   cur_style.flags[FL_BOLD]  = 1'b1;
      SGR_DIM:                    cur_style.flags[FL_DIM]   = 1'b1;
      SGR_UNDER:                  cur_style.flags[FL_UNDER] = 1'b1;
      SGR_BLINK:                  cur_style.flags[FL_BLINK] = 1'b1;
      SGR_REV:                    cur_style.flags[FL_REV]   = 1'b1;
      SGR_FONT_PRI:               cur_style.alt = 1'b0;
      SGR_FONT_ALT1, SGR_FONT_ALT2: cur_style.alt = 1'b1;
      SGR_NO_BOLD, SGR_NORMAL: begin
        cur_style.flags[FL_BOLD] = 1'b0;
        cur_style.flags[FL_DIM]  = 1'b0;
      end
      SGR_NO_UNDER:               cur_style.flags[FL_UNDER] = 1'b0;
      SGR_NO_BLINK:               cur_style.flags[FL_BLINK] = 1'b0;
      SGR_NO_REV:                 cur_style.flags[FL_REV]   = 1'b0;
      SGR_FG_UNDER: begin
        cur_style.fg              = dflt_fg;
        cur_style.flags[FL_UNDER] = 1'b1;
      end
      SGR_FG_DEFAULT: begin
        cur_style.fg              = dflt_fg;
        cur_style.flags[FL_UNDER] = 1'b0;
      end
      SGR_BG_DEFAULT:             cur_style.bg = dflt_bg;
      default: begin
        if (code >= SGR_FG_LO && code <= SGR_FG_HI)
          cur_style.fg = COLOR_W'(code - SGR_FG_LO);
        else if (code >= SGR_BG_LO && code <= SGR_BG_HI)
          cur_style.bg = COLOR_W'(code - SGR_BG_LO);
      end
    endcase
  endfunction

  // Advance the tracker by one parameter byte and return the style word it yields
  function automatic style_word_t next_style_word(logic [BYTE_W-1:0] b);
    style_word_t w;
    int unsigned v;
    if (b == CH_SEMI || b == CH_FINAL) begin
      if (tok_nonempty)
        apply_rendition(tok_value);
      tok_value    = '0;
      tok_nonempty = 1'b0;
      tok_frozen   = 1'b0;
    end else begin
      tok_nonempty = 1'b1;
      if (b >= CH_ZERO && b <= CH_NINE) begin
        if (!tok_frozen) begin
          v = tok_value * 10 + (b - CH_ZERO);
          tok_value = (v > ACC_MAX) ? ACC_MAX : BYTE_W'(v);
        end
      end else begin
        tok_frozen = 1'b1;
      end
    end
    w.style = cur_style;
    w.done  = (b == CH_FINAL);
    return w;
  endfunction

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s: got %0d, want %0d",
                                words_checked, name, got, want));
  endtask

  task automatic check_word(style_word_t w);
    words_checked++;
    check_field("fg_color", 8'(out_fg_color), 8'(w.style.fg));
    check_field("bg_color", 8'(out_bg_color), 8'(w.style.bg));
    check_field("bold", 8'(out_bold), 8'(w.style.flags[FL_BOLD]));
    check_field("dim", 8'(out_dim), 8'(w.style.flags[FL_DIM]));
    check_field("underline", 8'(out_underline), 8'(w.style.flags[FL_UNDER]));
    check_field("blink", 8'(out_blink), 8'(w.style.flags[FL_BLINK]));
    check_field("reverse", 8'(out_reverse), 8'(w.style.flags[FL_REV]));
    check_field("alternate_font", 8'(out_alternate_font), 8'(w.style.alt));
    check_field("sequence_done", 8'(out_sequence_done), 8'(w.done));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_styles.size() == 0)
        report_mismatch("style word arrived with nothing pending");
      else
        check_word(pending_styles.pop_front());
    end
  end

  // Receiver: a long hold-off when asked, else the rotating stall pattern
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= stall_mask[0];
      stall_mask = {stall_mask[0], stall_mask[15:1]};
    end
  end

  task automatic send_byte(logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, gap_max) : 0;
      repeat (gap) @(negedge clk) in_valid <= 1'b0;
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_param_byte <= b;
    do @(posedge clk); while (in_stall);
    pending_styles.push_back(next_style_word(b));
    bytes_sent++;
  endtask

  task automatic send_number(int unsigned value, int zeros);
    string s;
    s = $sformatf("%0d", value);
    repeat (zeros) s = {"0", s};
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i]);
  endtask

  task automatic send_code(logic [BYTE_W-1:0] code, bit last);
    send_number(32'(code), 0);
    send_byte(last ? CH_FINAL : CH_SEMI);
  endtask

  // Drop valid and wait until every pending word has been checked
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_styles.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEFAULT_FG:    dflt_fg    = data[COLOR_W-1:0];
      CFG_DEFAULT_BG:    dflt_bg    = data[COLOR_W-1:0];
      CFG_DEFAULT_FLAGS: dflt_flags = data[FLAGS_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Upper data bits above a colour field are don't-care; fill them at random
  task automatic program_defaults(logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg,
                                  logic [FLAGS_W-1:0] flags);
    write_reg(CFG_DEFAULT_FG, {(CFG_DATA_W-COLOR_W)'($urandom), fg});
    write_reg(CFG_DEFAULT_BG, {(CFG_DATA_W-COLOR_W)'($urandom), bg});
    write_reg(CFG_DEFAULT_FLAGS, flags);
  endtask

  function automatic logic [BYTE_W-1:0] pick_code();
    case ($urandom_range(0, 3))
      0:       return BYTE_W'(SGR_FG_LO + $urandom_range(0, 7));
      1:       return BYTE_W'(SGR_BG_LO + $urandom_range(0, 7));
      default: return named_codes[$urandom_range(0, 18)];
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_junk();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255));
    while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI || b == CH_FINAL);
    return b;
  endfunction

  task automatic send_random_token();
    case ($urandom_range(0, 19))
      0: ;  // empty token
      1: send_number($urandom_range(256, 99999), 0);
      2: begin
        send_byte(pick_junk());
        if ($urandom_range(0, 1) != 0)
          send_number($urandom_range(0, 99), 0);
      end
      3: begin
        send_number($urandom_range(0, 49), 0);
        send_byte(pick_junk());
        send_number($urandom_range(0, 9), 0);
      end
      4: send_number($urandom_range(0, 255), $urandom_range(0, 2));
      default: send_number(32'(pick_code()), ($urandom_range(0, 7) == 0) ? 1 : 0);
    endcase
  endtask

  task automatic send_random_sequence();
    int tokens;
    tokens = $urandom_range(1, 4);
    for (int t = 0; t < tokens; t++) begin
      send_random_token();
      send_byte((t == tokens - 1 && $urandom_range(0, 9) != 0) ? CH_FINAL : CH_SEMI);
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic shuffle_flow();
    gaps_on = ($urandom_range(0, 2) != 0);
    gap_max = $urandom_range(1, 8);
    case ($urandom_range(0, 3))
      0:       stall_mask = '0;
      1:       stall_mask = 16'hFFFE;
      default: stall_mask = 16'($urandom);
    endcase
  endtask

  // Flags, font, saturation, frozen tokens and empty tokens at reset defaults
  task automatic test_directed_tokens();
    send_code(SGR_BOLD, 1'b0);
    send_code(SGR_DIM, 1'b0);
    send_code(SGR_UNDER, 1'b0);
    send_code(SGR_BLINK, 1'b0);
    send_code(SGR_REV, 1'b0);
    send_code(SGR_FONT_ALT2, 1'b1);
    send_number(999, 0);
    send_byte(CH_SEMI);
    // non-digit first: later digits ignored, token acts as a reset
    send_byte(8'hFF);
    send_number(32'(SGR_REV), 0);
    send_byte(CH_SEMI);
    send_byte(CH_SEMI);
    send_byte(8'h00);
    send_byte(CH_FINAL);
    drain_results();
  endtask

  task automatic test_register_defaults();
    gaps_on    = 1'b1;
    stall_mask = 16'h0F30;
    for (int p = 0; p < 4; p++) begin
      drain_results();
      case (p)
        0:       program_defaults('0, '1, '1);
        1:       program_defaults('1, '0, '0);
        default: program_defaults(COLOR_W'($urandom), COLOR_W'($urandom),
                                  FLAGS_W'($urandom));
      endcase
      if (p == 2)
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
      send_code(SGR_FG_HI, 1'b0);
      send_code(SGR_BG_LO, 1'b0);
      send_code(SGR_FONT_ALT1, 1'b0);
      send_code(SGR_RESET, 1'b0);
      send_code(SGR_FG_UNDER, 1'b0);
      send_code(SGR_BG_HI, 1'b0);
      send_code(SGR_FG_DEFAULT, 1'b0);
      send_code(SGR_BG_DEFAULT, 1'b1);
    end
    drain_results();
  endtask

  task automatic test_code_sweep();
    shuffle_flow();
    foreach (named_codes[i])
      send_code(named_codes[i], $urandom_range(0, 3) == 0);
    for (int c = 0; c < 8; c++) begin
      send_code(BYTE_W'(SGR_FG_LO + c), 1'b0);
      send_code(BYTE_W'(SGR_BG_LO + c), c == 7);
    end
    drain_results();
  endtask

  // Hold the result side off while the sender keeps offering words
  task automatic test_backpressure();
    int start;
    gaps_on    = 1'b0;
    stall_mask = '0;
    hold_left  = HOLD_OFF_CYCLES;
    start      = bytes_sent;
    while (bytes_sent - start < 40)
      send_random_sequence();
    drain_results();
  endtask

  task automatic test_random_stream();
    int start;
    int next_shuffle;
    int next_reprogram;
    start          = bytes_sent;
    next_shuffle   = 0;
    next_reprogram = 300;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if (bytes_sent - start >= next_shuffle) begin
        shuffle_flow();
        next_shuffle += $urandom_range(60, 160);
      end
      if (bytes_sent - start >= next_reprogram) begin
        drain_results();
        program_defaults(COLOR_W'($urandom), COLOR_W'($urandom), FLAGS_W'($urandom));
        next_reprogram += 300;
      end
      if ($urandom_range(0, 6) == 0)
        send_noise();
      else
        send_random_sequence();
    end
    drain_results();
  endtask

  initial begin
    reset_tracker();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_tokens();
    test_register_defaults();
    test_code_sweep();
    test_backpressure();
    test_random_stream();

    stall_mask = '0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_styles.size() != 0)
      report_mismatch($sformatf("%0d style words never arrived", pending_styles.size()));

    $display("Checked %0d style words from %0d parameter bytes, %0d register writes;",
             words_checked, bytes_sent, cfg_writes);
    $display("bursty input, patterned output stalls and one long output hold-off.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
